>>> rtl/llf_pkg.sv
`timescale 1ns / 1ps

package llf_pkg;

    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 48;
    localparam int TASK_COUNT_W   = 3;
    localparam int TICK_W         = 32;
    localparam int TASK_ID_W      = 3;
    localparam int NUM_PARAM_REGS = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_TASK_COUNT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYPERPERIOD = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TASK0       = 4'd2;

    localparam int WORK_LSB     = 0;
    localparam int DEADLINE_LSB = 16;
    localparam int PERIOD_LSB   = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECR,
        ST_FINISH
    } llf_state_t;

    typedef struct packed {
        logic reload;
        logic wr_en;
    } store_ctrl_t;

endpackage

>>> rtl/llf_cfg_regs.sv
`timescale 1ns / 1ps

module llf_cfg_regs
    import llf_pkg::*;
#(
    parameter int MAX_TASKS  = 6,
    parameter int TIME_WIDTH = 16,
    parameter int CNT_W      = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [CNT_W-1:0]       used_count,
    output logic [TICK_W-1:0]      hyperperiod,
    output logic [TIME_WIDTH-1:0]  p_work [MAX_TASKS],
    output logic [TIME_WIDTH-1:0]  p_deadline [MAX_TASKS],
    output logic [TIME_WIDTH-1:0]  p_period [MAX_TASKS]
);

    logic [TASK_COUNT_W-1:0] task_count_reg;
    logic [TICK_W-1:0]       hyperperiod_reg;
    logic [TIME_WIDTH-1:0]   work_reg [MAX_TASKS];
    logic [TIME_WIDTH-1:0]   deadline_reg [MAX_TASKS];
    logic [TIME_WIDTH-1:0]   period_reg [MAX_TASKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg  <= TASK_COUNT_W'(1);
            hyperperiod_reg <= TICK_W'(1);
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                work_reg[k]     <= '0;
                deadline_reg[k] <= '0;
                period_reg[k]   <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TASK_COUNT)
            begin
                task_count_reg <= cfg_data[TASK_COUNT_W-1:0];
            end
            if (cfg_index == REG_HYPERPERIOD)
            begin
                hyperperiod_reg <= cfg_data[TICK_W-1:0];
            end
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                if (cfg_index == REG_TASK0 + CFG_INDEX_W'(k))
                begin
                    work_reg[k]     <= cfg_data[WORK_LSB +: TIME_WIDTH];
                    deadline_reg[k] <= cfg_data[DEADLINE_LSB +: TIME_WIDTH];
                    period_reg[k]   <= cfg_data[PERIOD_LSB +: TIME_WIDTH];
                end
            end
        end
    end

    assign used_count  = (task_count_reg > TASK_COUNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                                     : CNT_W'(task_count_reg);
    assign hyperperiod = hyperperiod_reg;
    assign p_work      = work_reg;
    assign p_deadline  = deadline_reg;
    assign p_period    = period_reg;

endmodule

>>> rtl/llf_task_store.sv
`timescale 1ns / 1ps

module llf_task_store
    import llf_pkg::*;
#(
    parameter int MAX_TASKS  = 6,
    parameter int TIME_WIDTH = 16,
    parameter int IDX_W      = 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  store_ctrl_t                  ctrl,
    input  logic [IDX_W-1:0]             idx,
    input  logic [TIME_WIDTH-1:0]        p_work [MAX_TASKS],
    input  logic [TIME_WIDTH-1:0]        p_deadline [MAX_TASKS],
    input  logic [TIME_WIDTH-1:0]        p_period [MAX_TASKS],
    input  logic [TIME_WIDTH-1:0]        wr_work,
    input  logic signed [TIME_WIDTH+1:0] wr_deadline,
    input  logic [TIME_WIDTH-1:0]        wr_period,
    output logic [TIME_WIDTH-1:0]        rd_work,
    output logic signed [TIME_WIDTH+1:0] rd_deadline,
    output logic [TIME_WIDTH-1:0]        rd_period
);

    logic [TIME_WIDTH-1:0]        work_reg [MAX_TASKS];
    logic signed [TIME_WIDTH+1:0] deadline_reg [MAX_TASKS];
    logic [TIME_WIDTH-1:0]        period_reg [MAX_TASKS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                work_reg[k]     <= '0;
                deadline_reg[k] <= '0;
                period_reg[k]   <= '0;
            end
        end
        else if (ctrl.reload)
        begin
            for (int k = 0; k < MAX_TASKS; k++)
            begin
                work_reg[k]     <= p_work[k];
                deadline_reg[k] <= {2'b00, p_deadline[k]};
                period_reg[k]   <= p_period[k];
            end
        end
        else if (ctrl.wr_en)
        begin
            work_reg[idx]     <= wr_work;
            deadline_reg[idx] <= wr_deadline;
            period_reg[idx]   <= wr_period;
        end
    end

    assign rd_work     = work_reg[idx];
    assign rd_deadline = deadline_reg[idx];
    assign rd_period   = period_reg[idx];

endmodule

>>> rtl/llf_step_unit.sv
`timescale 1ns / 1ps

module llf_step_unit
    import llf_pkg::*;
#(
    parameter int TIME_WIDTH = 16,
    parameter int LAX_W      = 19
)
(
    input  logic                         decr_pass,
    input  logic                         t_nonzero,
    input  logic                         is_best,
    input  logic                         found,
    input  logic signed [LAX_W-1:0]      best_lax,
    input  logic [TIME_WIDTH-1:0]        work,
    input  logic signed [TIME_WIDTH+1:0] deadline,
    input  logic [TIME_WIDTH-1:0]        period_cnt,
    input  logic [TIME_WIDTH-1:0]        p_work,
    input  logic [TIME_WIDTH-1:0]        p_deadline,
    input  logic [TIME_WIDTH-1:0]        p_period,
    output logic [TIME_WIDTH-1:0]        new_work,
    output logic signed [TIME_WIDTH+1:0] new_deadline,
    output logic [TIME_WIDTH-1:0]        new_period,
    output logic signed [LAX_W-1:0]      lax,
    output logic                         take,
    output logic                         miss
);

    localparam logic [TIME_WIDTH+1:0] DEADLINE_MIN = {1'b1, {(TIME_WIDTH+1){1'b0}}};

    always_comb
    begin
        new_work     = work;
        new_deadline = deadline;
        new_period   = period_cnt;
        miss         = 1'b0;
        if (decr_pass)
        begin
            if (deadline != DEADLINE_MIN)
            begin
                new_deadline = deadline - (TIME_WIDTH+2)'(1);
            end
            if (is_best)
            begin
                new_work = work - TIME_WIDTH'(1);
            end
        end
        else if (t_nonzero && period_cnt != '0)
        begin
            new_period = period_cnt - TIME_WIDTH'(1);
            if (period_cnt == TIME_WIDTH'(1))
            begin
                miss         = (work != '0);
                new_work     = p_work;
                new_deadline = {2'b00, p_deadline};
                new_period   = p_period;
            end
        end
        lax  = {new_deadline[TIME_WIDTH+1], new_deadline} - {3'b000, new_work};
        take = !decr_pass && (new_work != '0) && (!found || lax < best_lax);
    end

endmodule

>>> rtl/least_laxity_first_scheduler.sv
`timescale 1ns / 1ps

// Least-laxity-first scheduler for a periodic set of up to MAX_TASKS tasks.
// Each input item is one time tick; restart set to 1 reloads every task from
// its parameter register, clears the halt and runs tick zero. Each item gives
// exactly one result item: the chosen task, an idle flag, a deadline-miss
// flag, a done flag and the tick number.
// The configuration channel is always ready. Register writes are to be made
// only while the block is idle, which the block does not enforce; they do not
// reload the task state. A tick scans the n tasks in use one per cycle
// through a shared laxity unit, then makes a second pass to age the deadlines
// when a task was chosen. An item goes from idle through the scan pass and,
// if a task was chosen, the deadline pass to finish, which writes the result
// register; a done tick goes straight to finish. The next item can be taken
// in the cycle the result appears. The input is ready only between ticks.
// Results are held in an output register; the next item may be accepted and
// processed while a result is stalled, and the block waits before writing
// its new result until the stalled one is taken.
// Reset clears the task state, the time and the halt, and sets task_count
// and hyperperiod to 1 and all task parameters to 0.
module least_laxity_first_scheduler
    import llf_pkg::*;
#(
    parameter int MAX_TASKS  = 6,
    parameter int TIME_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   restart,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TASK_ID_W-1:0]   chosen_task,
    output logic                   idle,
    output logic                   deadline_miss,
    output logic                   done_res,
    output logic [TICK_W-1:0]      tick_number
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int LAX_W = TIME_WIDTH + 3;

    logic [CNT_W-1:0]             used_count;
    logic [TICK_W-1:0]            hyperperiod;
    logic [TIME_WIDTH-1:0]        p_work [MAX_TASKS];
    logic [TIME_WIDTH-1:0]        p_deadline [MAX_TASKS];
    logic [TIME_WIDTH-1:0]        p_period [MAX_TASKS];

    llf_state_t                   state_reg, state_next;
    logic [CNT_W-1:0]             k_reg, k_next;
    logic [IDX_W-1:0]             best_reg, best_next;
    logic signed [LAX_W-1:0]      best_lax_reg, best_lax_next;
    logic                         found_reg, found_next;
    logic                         miss_reg, miss_next;
    logic                         done_reg, done_next;
    logic [TICK_W-1:0]            time_reg, time_next;
    logic                         halted_reg, halted_next;

    logic                         out_valid_reg, out_valid_next;
    logic [TASK_ID_W-1:0]         out_chosen_reg, out_chosen_next;
    logic                         out_idle_reg, out_idle_next;
    logic                         out_miss_reg, out_miss_next;
    logic                         out_done_reg, out_done_next;
    logic [TICK_W-1:0]            out_tick_reg, out_tick_next;

    store_ctrl_t                  store_ctrl;
    logic [IDX_W-1:0]             idx;
    logic [TIME_WIDTH-1:0]        rd_work, new_work;
    logic signed [TIME_WIDTH+1:0] rd_deadline, new_deadline;
    logic [TIME_WIDTH-1:0]        rd_period, new_period;
    logic signed [LAX_W-1:0]      lax;
    logic                         take, step_miss;
    logic                         in_fire, eff_halted;
    logic [TICK_W-1:0]            eff_time;

    assign cfg_ready = 1'b1;
    assign idx       = k_reg[IDX_W-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    llf_cfg_regs #(
        .MAX_TASKS  (MAX_TASKS),
        .TIME_WIDTH (TIME_WIDTH),
        .CNT_W      (CNT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .used_count  (used_count),
        .hyperperiod (hyperperiod),
        .p_work      (p_work),
        .p_deadline  (p_deadline),
        .p_period    (p_period)
    );

    llf_task_store #(
        .MAX_TASKS  (MAX_TASKS),
        .TIME_WIDTH (TIME_WIDTH),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (store_ctrl),
        .idx         (idx),
        .p_work      (p_work),
        .p_deadline  (p_deadline),
        .p_period    (p_period),
        .wr_work     (new_work),
        .wr_deadline (new_deadline),
        .wr_period   (new_period),
        .rd_work     (rd_work),
        .rd_deadline (rd_deadline),
        .rd_period   (rd_period)
    );

    llf_step_unit #(
        .TIME_WIDTH (TIME_WIDTH),
        .LAX_W      (LAX_W)
    ) u_step (
        .decr_pass    (state_reg == ST_DECR),
        .t_nonzero    (time_reg != '0),
        .is_best      (best_reg == idx),
        .found        (found_reg),
        .best_lax     (best_lax_reg),
        .work         (rd_work),
        .deadline     (rd_deadline),
        .period_cnt   (rd_period),
        .p_work       (p_work[idx]),
        .p_deadline   (p_deadline[idx]),
        .p_period     (p_period[idx]),
        .new_work     (new_work),
        .new_deadline (new_deadline),
        .new_period   (new_period),
        .lax          (lax),
        .take         (take),
        .miss         (step_miss)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            miss_reg      <= 1'b0;
            done_reg      <= 1'b0;
            time_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            miss_reg      <= miss_next;
            done_reg      <= done_next;
            time_reg      <= time_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_lax_reg   <= best_lax_next;
        out_chosen_reg <= out_chosen_next;
        out_idle_reg   <= out_idle_next;
        out_miss_reg   <= out_miss_next;
        out_done_reg   <= out_done_next;
        out_tick_reg   <= out_tick_next;
    end

    assign eff_halted = restart ? 1'b0 : halted_reg;
    assign eff_time   = restart ? '0 : time_reg;

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        best_next       = best_reg;
        best_lax_next   = best_lax_reg;
        found_next      = found_reg;
        miss_next       = miss_reg;
        done_next       = done_reg;
        time_next       = time_reg;
        halted_next     = halted_reg;
        store_ctrl      = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_chosen_next = out_chosen_reg;
        out_idle_next   = out_idle_reg;
        out_miss_next   = out_miss_reg;
        out_done_next   = out_done_reg;
        out_tick_next   = out_tick_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    store_ctrl.reload = restart;
                    time_next   = eff_time;
                    halted_next = eff_halted;
                    done_next   = eff_halted || (eff_time >= hyperperiod);
                    k_next      = '0;
                    best_next   = '0;
                    found_next  = 1'b0;
                    miss_next   = 1'b0;
                    state_next  = (eff_halted || (eff_time >= hyperperiod)) ? ST_FINISH
                                                                            : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == used_count)
                begin
                    k_next     = '0;
                    state_next = found_reg ? ST_DECR : ST_FINISH;
                end
                else
                begin
                    store_ctrl.wr_en = 1'b1;
                    miss_next        = miss_reg || step_miss;
                    if (take)
                    begin
                        found_next    = 1'b1;
                        best_next     = idx;
                        best_lax_next = lax;
                    end
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_DECR:
            begin
                if (k_reg == used_count)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    store_ctrl.wr_en = 1'b1;
                    k_next           = k_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_done_next   = done_reg;
                    out_chosen_next = (!done_reg && found_reg) ? TASK_ID_W'(best_reg) : '0;
                    out_idle_next   = !done_reg && !found_reg;
                    out_miss_next   = !done_reg && miss_reg;
                    out_tick_next   = time_reg;
                    if (!done_reg)
                    begin
                        time_next   = time_reg + TICK_W'(1);
                        halted_next = miss_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign chosen_task   = out_chosen_reg;
    assign idle          = out_idle_reg;
    assign deadline_miss = out_miss_reg;
    assign done_res      = out_done_reg;
    assign tick_number   = out_tick_reg;

    a_decr_needs_choice: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECR |-> found_reg)
        else $error("Deadline pass entered without a chosen task.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DECR) |-> k_reg <= used_count)
        else $error("Task counter ran past the tasks in use.");

    a_done_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> chosen_task == '0 && !idle && !deadline_miss)
        else $error("Done result carries tick outcome flags.");

    a_halt_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> out_valid_reg && out_miss_reg)
        else $error("Scheduler halted without reporting a deadline miss.");

    a_chosen_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle |-> chosen_task == '0 && !done_res)
        else $error("Idle result names a task or reports done.");

endmodule
